### hw/rtl/awb_pkg.sv
// Package with shared constants and types for the affine warp bilinear sampler.
`timescale 1ns / 1ps
package awb_pkg;
    localparam int MAX_SRC_DIM_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 8;
    localparam int COEF_W = 32;
    localparam int PIX_W = 8;
    localparam int DIM_W = 9;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SH = 3'd7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef logic [7:0] t_pix;
endpackage

### hw/rtl/affine_warp_bilinear_sampler_top.sv
// Top level of the affine warp bilinear sampler: source store, mapping and blend pipeline.
`timescale 1ns / 1ps
// Usage:
// The input channel (i_valid / o_stall) carries items. A write item (cmd 0) stores one
// RGB source pixel; a render item (cmd 1) maps destination pixel (pix_x, pix_y) through
// the affine coefficients and yields one result item on the output channel
// (o_valid / i_stall). Write items give no result.
// The source image lives in four banked synchronous memories (even/odd column by
// even/odd row), so the four neighbours of a point are read in the same cycle.
// Throughput is one item per clock unless the receiver stalls. Stages: map multiply, sum,
// memory read, horizontal blend, vertical blend. The whole pipeline advances together;
// when the receiver stalls with a result held at the output, the pipeline freezes and
// o_stall is raised, so nothing is lost. A write followed by renders that read the same
// pixel is forwarded by ordering: the write reaches the memory in its stage before a later
// render reads it. Configuration is written through i_cfg_valid / o_cfg_ready
// (always ready) while idle, which the user must ensure; the block does not enforce it.
// Reset (i_rst_n low, synchronous) restores the identity transform and 256 x 256
// dimensions and empties the pipeline; the source image is undefined until written.
module affine_warp_bilinear_sampler_top #(
    parameter int WEIGHT_BITS = awb_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [awb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [awb_pkg::COEF_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_pix_x,
    input  logic [7:0]                    i_pix_y,
    input  logic [7:0]                    i_in_red,
    input  logic [7:0]                    i_in_green,
    input  logic [7:0]                    i_in_blue,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_sample_valid,
    output logic [7:0]                    o_dest_x,
    output logic [7:0]                    o_dest_y,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue
);
    import awb_pkg::*;

    // The store size follows the 8-bit pixel coordinates.
    localparam int MAX_SRC_DIM = MAX_SRC_DIM_DEF;
    localparam int AW = $clog2(MAX_SRC_DIM);
    localparam int HW = AW - 1;
    localparam int BD = (MAX_SRC_DIM + 1) / 2;
    localparam int DEP = BD * BD;
    localparam int BAW = (HW < 1) ? 1 : 2 * HW;
    localparam int WB = WEIGHT_BITS;
    localparam int MULW = COEF_W + PIX_W + 1;
    localparam int SUMW = MULW + 2;
    localparam int DMW = AW + 1;
    localparam logic [DMW-1:0] DMAX = DMW'(MAX_SRC_DIM);
    localparam logic [WB:0] WONE = (WB+1)'(1) << WB;
    localparam int HBW = PIX_W + WB + 1;
    localparam int VBW = HBW + WB + 1;

    // Configuration registers.
    logic signed [COEF_W-1:0] r_cxx, r_cxy, r_cx0, r_cyx, r_cyy, r_cy0;
    logic [DIM_W-1:0] r_sw, r_sh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cxx <= 32'sd65536;
            r_cxy <= '0;
            r_cx0 <= '0;
            r_cyx <= '0;
            r_cyy <= 32'sd65536;
            r_cy0 <= '0;
            r_sw <= 9'd256;
            r_sh <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_XX: r_cxx <= i_cfg_data;
                REG_XY: r_cxy <= i_cfg_data;
                REG_X0: r_cx0 <= i_cfg_data;
                REG_YX: r_cyx <= i_cfg_data;
                REG_YY: r_cyy <= i_cfg_data;
                REG_Y0: r_cy0 <= i_cfg_data;
                REG_SW: r_sw <= i_cfg_data[DIM_W-1:0];
                REG_SH: r_sh <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Dimensions saturated to the store size.
    logic [DMW-1:0] w_dim_w, w_dim_h;
    always_comb begin
        w_dim_w = ({{(DMW+DIM_W){1'b0}}, r_sw} > (DMW+2*DIM_W)'(MAX_SRC_DIM)) ? DMAX
                : DMW'(r_sw);
        w_dim_h = ({{(DMW+DIM_W){1'b0}}, r_sh} > (DMW+2*DIM_W)'(MAX_SRC_DIM)) ? DMAX
                : DMW'(r_sh);
    end

    // Pipeline advance: freeze while a result waits under stall.
    logic w_adv;
    assign w_adv = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    logic w_acc;
    assign w_acc = i_valid && w_adv;

    // Stage 1: products.
    logic r1_v, r1_cmd;
    logic [7:0] r1_x, r1_y;
    logic [23:0] r1_rgb;
    logic signed [MULW-1:0] r1_pxx, r1_pxy, r1_pyx, r1_pyy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_adv) r1_v <= i_valid;
        if (w_adv) begin
            r1_cmd <= i_cmd;
            r1_x <= i_pix_x;
            r1_y <= i_pix_y;
            r1_rgb <= {i_in_red, i_in_green, i_in_blue};
            r1_pxx <= MULW'(r_cxx * $signed({1'b0, i_pix_x}));
            r1_pxy <= MULW'(r_cxy * $signed({1'b0, i_pix_y}));
            r1_pyx <= MULW'(r_cyx * $signed({1'b0, i_pix_x}));
            r1_pyy <= MULW'(r_cyy * $signed({1'b0, i_pix_y}));
        end
    end

    // Stage 2: sums, range test, bank addresses.
    logic signed [SUMW-1:0] w_sx, w_sy;
    logic [SUMW-17:0] w_xi, w_yi;
    logic w_in;
    assign w_sx = SUMW'(r1_pxx) + SUMW'(r1_pxy) + SUMW'(r_cx0);
    assign w_sy = SUMW'(r1_pyx) + SUMW'(r1_pyy) + SUMW'(r_cy0);
    assign w_xi = w_sx[SUMW-1:16];
    assign w_yi = w_sy[SUMW-1:16];
    always_comb begin
        w_in = !w_sx[SUMW-1] && !w_sy[SUMW-1]
            && ((w_xi + 1'b1) < (SUMW-16)'(w_dim_w))
            && ((w_yi + 1'b1) < (SUMW-16)'(w_dim_h));
    end

    logic r2_v, r2_cmd, r2_in;
    logic [7:0] r2_x, r2_y;
    logic [23:0] r2_rgb;
    logic [AW-1:0] r2_xi, r2_yi;
    logic [WB-1:0] r2_fx, r2_fy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_adv) r2_v <= r1_v;
        if (w_adv) begin
            r2_cmd <= r1_cmd;
            r2_x <= r1_x;
            r2_y <= r1_y;
            r2_rgb <= r1_rgb;
            r2_in <= w_in;
            r2_xi <= w_xi[AW-1:0];
            r2_yi <= w_yi[AW-1:0];
            r2_fx <= w_sx[15:16-WB];
            r2_fy <= w_sy[15:16-WB];
        end
    end

    // Banked source store: bank index {row lsb, col lsb}. Writes happen in stage 2.
    logic [23:0] r_mem0 [DEP];
    logic [23:0] r_mem1 [DEP];
    logic [23:0] r_mem2 [DEP];
    logic [23:0] r_mem3 [DEP];

    // Column of the even and odd neighbor, likewise rows.
    logic [AW-1:0] w_x1, w_y1;
    logic [HW-1:0] w_ce, w_co, w_re, w_ro;
    assign w_x1 = r2_xi + 1'b1;
    assign w_y1 = r2_yi + 1'b1;
    assign w_ce = r2_xi[0] ? w_x1[AW-1:1] : r2_xi[AW-1:1];
    assign w_co = r2_xi[AW-1:1];
    assign w_re = r2_yi[0] ? w_y1[AW-1:1] : r2_yi[AW-1:1];
    assign w_ro = r2_yi[AW-1:1];

    logic w_wr;
    logic [BAW-1:0] w_wa;
    assign w_wr = w_adv && r2_v && (r2_cmd == CMD_WRITE);
    assign w_wa = {r2_y[AW-1:1], r2_x[AW-1:1]};

    logic [23:0] r_q0, r_q1, r_q2, r_q3;
    always_ff @(posedge i_clk) begin
        if (w_wr && !r2_x[0] && !r2_y[0]) r_mem0[w_wa] <= r2_rgb;
        if (w_adv) r_q0 <= r_mem0[{w_re, w_ce}];
    end
    always_ff @(posedge i_clk) begin
        if (w_wr && r2_x[0] && !r2_y[0]) r_mem1[w_wa] <= r2_rgb;
        if (w_adv) r_q1 <= r_mem1[{w_re, w_co}];
    end
    always_ff @(posedge i_clk) begin
        if (w_wr && !r2_x[0] && r2_y[0]) r_mem2[w_wa] <= r2_rgb;
        if (w_adv) r_q2 <= r_mem2[{w_ro, w_ce}];
    end
    always_ff @(posedge i_clk) begin
        if (w_wr && r2_x[0] && r2_y[0]) r_mem3[w_wa] <= r2_rgb;
        if (w_adv) r_q3 <= r_mem3[{w_ro, w_co}];
    end

    // Stage 3 holds the read data; parity picks which bank is left/top.
    logic r3_v, r3_in, r3_px, r3_py;
    logic [7:0] r3_x, r3_y;
    logic [WB-1:0] r3_fx, r3_fy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_adv) r3_v <= r2_v && (r2_cmd == CMD_RENDER);
        if (w_adv) begin
            r3_in <= r2_in;
            r3_px <= r2_xi[0];
            r3_py <= r2_yi[0];
            r3_x <= r2_x;
            r3_y <= r2_y;
            r3_fx <= r2_fx;
            r3_fy <= r2_fy;
        end
    end

    logic [23:0] w_p00, w_p01, w_p10, w_p11, w_te, w_to, w_be, w_bo;
    always_comb begin
        w_te = r3_py ? r_q2 : r_q0;
        w_to = r3_py ? r_q3 : r_q1;
        w_be = r3_py ? r_q0 : r_q2;
        w_bo = r3_py ? r_q1 : r_q3;
        w_p00 = r3_px ? w_to : w_te;
        w_p01 = r3_px ? w_te : w_to;
        w_p10 = r3_px ? w_bo : w_be;
        w_p11 = r3_px ? w_be : w_bo;
    end

    // Stage 4: horizontal blend per channel.
    logic [WB:0] w_wx, w_wy;
    assign w_wx = WONE - (WB+1)'(r3_fx);
    logic [HBW-1:0] r4_top [3];
    logic [HBW-1:0] r4_bot [3];
    logic r4_v, r4_in;
    logic [7:0] r4_x, r4_y;
    logic [WB-1:0] r4_fy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_adv) r4_v <= r3_v;
        if (w_adv) begin
            r4_in <= r3_in;
            r4_x <= r3_x;
            r4_y <= r3_y;
            r4_fy <= r3_fy;
            for (int c = 0; c < 3; c++) begin
                r4_top[c] <= HBW'(w_p00[16-8*c +: 8] * w_wx)
                           + HBW'(w_p01[16-8*c +: 8] * r3_fx);
                r4_bot[c] <= HBW'(w_p10[16-8*c +: 8] * w_wx)
                           + HBW'(w_p11[16-8*c +: 8] * r3_fx);
            end
        end
    end

    // Stage 5: vertical blend into the output register.
    assign w_wy = WONE - (WB+1)'(r4_fy);
    logic [VBW-1:0] w_v [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_v[c] = VBW'(r4_top[c] * w_wy) + VBW'(r4_bot[c] * r4_fy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (w_adv) o_valid <= r4_v;
        if (w_adv) begin
            o_sample_valid <= r4_in;
            o_dest_x <= r4_x;
            o_dest_y <= r4_y;
            o_out_red <= r4_in ? w_v[0][2*WB +: 8] : 8'd0;
            o_out_green <= r4_in ? w_v[1][2*WB +: 8] : 8'd0;
            o_out_blue <= r4_in ? w_v[2][2*WB +: 8] : 8'd0;
        end
    end

    // Assertions.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_x) && $stable(o_out_red))
        else $error("result changed under stall");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_valid |-> o_out_red == 8'd0 && o_out_blue == 8'd0)
        else $error("invalid sample carries color");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without cause");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r4_v) && $stable(r3_v))
        else $error("pipeline moved while frozen");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r1_v)
        else $error("accepted item lost");
endmodule

### tb/sv/tb_affine_warp_bilinear_sampler_top.sv
// Self-checking testbench for the affine warp bilinear sampler top level.
`timescale 1ns / 1ps
module tb_affine_warp_bilinear_sampler_top;
    import awb_pkg::*;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PIPE_DRAIN  = 20;
    localparam int  STORE_DIM   = 256;
    localparam int  FRAC_SHIFT  = 16 - WEIGHT_BITS_DEF;
    localparam int  WGT_ONE     = 1 << WEIGHT_BITS_DEF;

    // One result item as the block reports it.
    typedef struct packed {
        logic       ok;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_sample;

    // One row of the directed stimulus; typed rows carry their own expected sample.
    typedef struct packed {
        logic       cmd;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        t_sample    want;
    } t_dir_row;

    localparam int DIR_ROWS = 14;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{CMD_WRITE,  8'd0,   8'd0,   8'hFF, 8'h00, 8'h80, 1'b0, '0},
        '{CMD_WRITE,  8'd1,   8'd0,   8'h00, 8'hFF, 8'h7F, 1'b0, '0},
        '{CMD_WRITE,  8'd0,   8'd1,   8'h80, 8'h80, 8'h80, 1'b0, '0},
        '{CMD_WRITE,  8'd1,   8'd1,   8'h01, 8'h02, 8'h03, 1'b0, '0},
        '{CMD_RENDER, 8'd0,   8'd0,   8'h5A, 8'hA5, 8'hFF, 1'b1,
          '{1'b1, 8'd0, 8'd0, 8'hFF, 8'h00, 8'h80}},
        '{CMD_WRITE,  8'd254, 8'd254, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_WRITE,  8'd255, 8'd254, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_WRITE,  8'd254, 8'd255, 8'hAA, 8'h55, 8'hAA, 1'b0, '0},
        '{CMD_WRITE,  8'd255, 8'd255, 8'h55, 8'hAA, 8'h55, 1'b0, '0},
        '{CMD_RENDER, 8'd254, 8'd254, 8'h00, 8'h00, 8'h00, 1'b1,
          '{1'b1, 8'd254, 8'd254, 8'h00, 8'h00, 8'h00}},
        // Last column and last row have no right or lower neighbor.
        '{CMD_RENDER, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{1'b0, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00}},
        '{CMD_RENDER, 8'd255, 8'd0,   8'h00, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'd255, 8'd0,   8'h00, 8'h00, 8'h00}},
        '{CMD_RENDER, 8'd0,   8'd255, 8'h00, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'd0,   8'd255, 8'h00, 8'h00, 8'h00}},
        '{CMD_RENDER, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_cmd;
    logic [7:0]           i_pix_x;
    logic [7:0]           i_pix_y;
    logic [7:0]           i_in_red;
    logic [7:0]           i_in_green;
    logic [7:0]           i_in_blue;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_sample_valid;
    logic [7:0]           o_dest_x;
    logic [7:0]           o_dest_y;
    logic [7:0]           o_out_red;
    logic [7:0]           o_out_green;
    logic [7:0]           o_out_blue;

    // Shadow copy of the transform, the dimensions and the source image.
    logic signed [31:0] coef_xx, coef_xy, coef_x0, coef_yx, coef_yy, coef_y0;
    int                 img_w, img_h;
    logic [23:0]        src_img [STORE_DIM*STORE_DIM];
    bit                 src_seen [STORE_DIM*STORE_DIM];

    t_sample pending_samples [$];
    int      cycles;
    int      fail_count;
    int      items_sent;
    int      renders_seen;
    int      valid_seen;
    int      send_idle_pct;
    int      rcv_idle_pct;
    int      hold_cycles;

    affine_warp_bilinear_sampler_top dut (.*);

    // Clock and cycle limit.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** affine_warp_bilinear_sampler_top: FAILED **");
            $finish;
        end
    end

    // Map a destination pixel to its source cell and weights.
    function automatic void map_dest(input logic [7:0] px, input logic [7:0] py,
                                     output bit ok, output int cell_x, output int cell_y,
                                     output int wx, output int wy);
        longint sx;
        longint sy;
        sx = longint'(coef_xx) * longint'(px) + longint'(coef_xy) * longint'(py)
             + longint'(coef_x0);
        sy = longint'(coef_yx) * longint'(px) + longint'(coef_yy) * longint'(py)
             + longint'(coef_y0);
        ok = 1'b0;
        cell_x = 0;
        cell_y = 0;
        wx = 0;
        wy = 0;
        if (sx >= 0 && sy >= 0 && (sx >>> 16) + 1 < img_w && (sy >>> 16) + 1 < img_h) begin
            ok = 1'b1;
            cell_x = int'(sx >>> 16);
            cell_y = int'(sy >>> 16);
            wx = int'(sx & 64'hFFFF) >> FRAC_SHIFT;
            wy = int'(sy & 64'hFFFF) >> FRAC_SHIFT;
        end
    endfunction

    // Bilinear blend of the four stored neighbors, truncated per channel.
    function automatic t_sample blend_sample(input logic [7:0] px, input logic [7:0] py);
        t_sample res;
        bit      ok;
        int      cx, cy, wx, wy, top, bot, val;
        logic [23:0] p00, p01, p10, p11;
        res = '0;
        res.dx = px;
        res.dy = py;
        map_dest(px, py, ok, cx, cy, wx, wy);
        if (ok) begin
            p00 = src_img[cy*STORE_DIM + cx];
            p01 = src_img[cy*STORE_DIM + cx + 1];
            p10 = src_img[(cy+1)*STORE_DIM + cx];
            p11 = src_img[(cy+1)*STORE_DIM + cx + 1];
            res.ok = 1'b1;
            for (int c = 0; c < 3; c++) begin
                top = p00[16-8*c +: 8] * (WGT_ONE - wx) + p01[16-8*c +: 8] * wx;
                bot = p10[16-8*c +: 8] * (WGT_ONE - wx) + p11[16-8*c +: 8] * wx;
                val = (top * (WGT_ONE - wy) + bot * wy) >> (2 * WEIGHT_BITS_DEF);
                if (val > 255) val = 255;
                case (c)
                    0: res.red = val[7:0];
                    1: res.green = val[7:0];
                    default: res.blue = val[7:0];
                endcase
            end
        end
        return res;
    endfunction

    // Offer one item, hold it until accepted, then book it in the shadow model.
    task automatic send_item(input logic cmd, input logic [7:0] px, input logic [7:0] py,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input bit typed, input t_sample want);
        bit taken;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_pix_x <= px;
        i_pix_y <= py;
        i_in_red <= red;
        i_in_green <= green;
        i_in_blue <= blue;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        items_sent++;
        if (cmd == CMD_WRITE) begin
            src_img[int'(py)*STORE_DIM + int'(px)] = {red, green, blue};
            src_seen[int'(py)*STORE_DIM + int'(px)] = 1'b1;
        end else if (typed) begin
            pending_samples.push_back(want);
        end else begin
            pending_samples.push_back(blend_sample(px, py));
        end
    endtask

    // Render a destination pixel, first filling any neighbor never stored.
    task automatic render_pixel(input logic [7:0] px, input logic [7:0] py);
        bit ok;
        int cx, cy, wx, wy, addr;
        map_dest(px, py, ok, cx, cy, wx, wy);
        if (ok) begin
            for (int k = 0; k < 4; k++) begin
                addr = (cy + k/2)*STORE_DIM + cx + k%2;
                if (!src_seen[addr])
                    send_item(CMD_WRITE, 8'((cx + k%2)), 8'((cy + k/2)), 8'($urandom),
                              8'($urandom), 8'($urandom), 1'b0, '0);
            end
        end
        send_item(CMD_RENDER, px, py, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    // Stop offering, wait for every result, let in-flight writes settle.
    task automatic drain_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Write all eight registers back to back while the block is idle.
    task automatic load_regs(input logic [31:0] vals [8]);
        bit done;
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            done = 1'b0;
            while (!done) begin
                @(negedge i_clk);
                done = o_cfg_ready;
                @(posedge i_clk);
            end
            case (CFG_IDX_W'(k))
                REG_XX: coef_xx = vals[k];
                REG_XY: coef_xy = vals[k];
                REG_X0: coef_x0 = vals[k];
                REG_YX: coef_yx = vals[k];
                REG_YY: coef_yy = vals[k];
                REG_Y0: coef_y0 = vals[k];
                REG_SW: img_w = (vals[k][8:0] > STORE_DIM) ? STORE_DIM : int'(vals[k][8:0]);
                default: img_h = (vals[k][8:0] > STORE_DIM) ? STORE_DIM : int'(vals[k][8:0]);
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when the sender asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_stall <= (rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
        end
    end

    // Compare each accepted result item against the oldest expected sample.
    always @(negedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result item dest (%0d,%0d)", o_dest_x, o_dest_y);
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                renders_seen++;
                if (o_sample_valid) valid_seen++;
                if (o_sample_valid !== want.ok) begin
                    $error("sample_valid expected %0d got %0d", want.ok, o_sample_valid);
                    fail_count++;
                end
                if (o_dest_x !== want.dx) begin
                    $error("dest_x expected %0d got %0d", want.dx, o_dest_x);
                    fail_count++;
                end
                if (o_dest_y !== want.dy) begin
                    $error("dest_y expected %0d got %0d", want.dy, o_dest_y);
                    fail_count++;
                end
                if (o_out_red !== want.red) begin
                    $error("out_red expected %0d got %0d", want.red, o_out_red);
                    fail_count++;
                end
                if (o_out_green !== want.green) begin
                    $error("out_green expected %0d got %0d", want.green, o_out_green);
                    fail_count++;
                end
                if (o_out_blue !== want.blue) begin
                    $error("out_blue expected %0d got %0d", want.blue, o_out_blue);
                    fail_count++;
                end
            end
        end
    end

    // Main stimulus sequence.
    initial begin
        logic [31:0] regs [8];
        logic [7:0]  px, py;
        int          span;
        cycles = 0;
        fail_count = 0;
        items_sent = 0;
        renders_seen = 0;
        valid_seen = 0;
        send_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_cmd = CMD_WRITE;
        i_pix_x = '0;
        i_pix_y = '0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        coef_xx = 32'sd65536;
        coef_xy = '0;
        coef_x0 = '0;
        coef_yx = '0;
        coef_yy = 32'sd65536;
        coef_y0 = '0;
        img_w = STORE_DIM;
        img_h = STORE_DIM;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset transform.
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIR_TAB[r].cmd, DIR_TAB[r].px, DIR_TAB[r].py, DIR_TAB[r].red,
                      DIR_TAB[r].green, DIR_TAB[r].blue, DIR_TAB[r].typed, DIR_TAB[r].want);
        drain_block();

        // Half-pixel offset blends four neighbors; oversized width and height saturate.
        regs = '{32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0001_0000,
                 32'h0000_8000, 32'h1FF, 32'h101};
        load_regs(regs);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd254, 8'd254);
        render_pixel(8'd253, 8'd0);
        drain_block();

        // Zero and one as dimensions, then the coefficient extremes.
        regs = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h1};
        load_regs(regs);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd5, 8'd7);
        drain_block();
        regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h100, 32'h100};
        load_regs(regs);
        render_pixel(8'd255, 8'd255);
        render_pixel(8'd0, 8'd255);
        render_pixel(8'd255, 8'd0);
        drain_block();

        // Random phases: new transform each time, idling pattern by phase.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 34; rcv_idle_pct = 55; end
                1: begin send_idle_pct = 55; rcv_idle_pct = 34; end
                default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            span = ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 24);
            for (int k = 0; k < 6; k++)
                regs[k] = 32'($signed($urandom_range(0, 262144)) - 131072);
            if ($urandom_range(1)) begin
                regs[0] = 32'h0001_0000 + 32'($signed($urandom_range(0, 8192)) - 4096);
                regs[4] = 32'h0001_0000 + 32'($signed($urandom_range(0, 8192)) - 4096);
            end
            regs[2] = $urandom_range(0, 3 << 16);
            regs[5] = $urandom_range(0, 3 << 16);
            regs[6] = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 511)) : span;
            regs[7] = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 511)) : span;
            load_regs(regs);
            if (ph == 1) hold_cycles = 300;
            // Each phase stops at its share of the item budget, fill writes included.
            for (int n = 0; n < 125 && items_sent < 125 * (ph + 1) + 40; n++) begin
                if ($urandom_range(3) == 0) begin
                    px = $urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(0, 31));
                    py = $urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(0, 31));
                    send_item(CMD_WRITE, px, py, 8'($urandom), 8'($urandom), 8'($urandom),
                              1'b0, '0);
                end else begin
                    px = $urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 31));
                    py = $urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 31));
                    render_pixel(px, py);
                end
            end
            drain_block();
        end

        $display("Sent %0d items; checked %0d render results, %0d of them in-bounds blends.",
                 items_sent, renders_seen, valid_seen);
        if (fail_count == 0) begin
            $display("** affine_warp_bilinear_sampler_top: PASSED **");
        end else begin
            $display("** affine_warp_bilinear_sampler_top: FAILED **");
        end
        $finish;
    end
endmodule
